// ----- rtl/darst_pkg.sv -----
package darst_pkg;

  localparam int DATE_W = 21;
  localparam int AMT_W  = 32;
  localparam int SUM_W  = 48;
  localparam int ACC_W  = 64;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_SAT  = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [DATE_W-1:0]       date;
    logic signed [SUM_W-1:0] sum;
  } entry_t;

endpackage

// ----- rtl/darst_if.sv -----
interface darst_req_if;
  import darst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [DATE_W-1:0]       start_date;
  logic [DATE_W-1:0]       end_date;
  logic signed [AMT_W-1:0] amount;

  modport source (output valid, req_type, start_date, end_date, amount, input ready);
  modport sink   (input valid, req_type, start_date, end_date, amount, output ready);
endinterface

interface darst_rsp_if;
  import darst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [SUM_W-1:0] total;

  modport source (output valid, status, total, input ready);
  modport sink   (input valid, status, total, output ready);
endinterface

// ----- rtl/darst_mem.sv -----
module darst_mem #(
  parameter int DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  darst_pkg::entry_t             wr_entry_i,
  output darst_pkg::entry_t             rd_entry_o
);
  import darst_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

// ----- rtl/dated_amount_range_sum_table.sv -----
// One item at a time: a new request is taken only once the result of the last one has been
// offered. Each item scans the claimed entries one per cycle through the single read port of
// the entry memory; an add that hits an existing date ends the scan early.
// Reset: clears the fill count, so the table reads empty at once; no clearing pass.
module dated_amount_range_sum_table #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  darst_req_if.sink   req_i,
  darst_rsp_if.source rsp_o
);
  import darst_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_PUSH
  } state_e;

  state_e                  state_q;
  logic                    is_query_q;
  logic [DATE_W-1:0]       start_q;
  logic [DATE_W-1:0]       end_q;
  logic signed [AMT_W-1:0] amt_q;
  logic [CW-1:0]           addr_q;
  logic [CW-1:0]           count_q;
  logic                    pend_q;
  logic [AW-1:0]           rd_idx_q;
  logic                    found_q;
  logic [AW-1:0]           hit_idx_q;
  logic signed [SUM_W-1:0] hit_sum_q;
  logic signed [ACC_W-1:0] acc_q;
  status_e                 status_q;
  logic signed [SUM_W-1:0] total_q;
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic signed [SUM_W-1:0] out_total_q;

  logic                    accept;
  logic                    issue;
  logic                    hit_add;
  logic                    in_range;
  logic                    has_room;
  logic                    upd_sat;
  logic                    acc_sat;
  logic signed [SUM_W:0]   upd;
  logic signed [SUM_W-1:0] upd_clamped;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  entry_t                  wr_entry;
  entry_t                  rd_entry;

  assign accept   = req_i.valid && req_i.ready;
  assign has_room = count_q < CW'(MAX_ENTRIES);
  assign hit_add  = pend_q && !is_query_q && (rd_entry.date == start_q);
  assign in_range = pend_q && (rd_entry.date >= start_q) && (rd_entry.date <= end_q);
  assign issue    = (state_q == ST_SCAN) && (addr_q < count_q) && !hit_add;

  always_comb begin
    upd         = (SUM_W + 1)'(hit_sum_q) + (SUM_W + 1)'(amt_q);
    upd_sat     = upd[SUM_W] != upd[SUM_W-1];
    upd_clamped = upd_sat ? (upd[SUM_W] ? SUM_MIN : SUM_MAX) : upd[SUM_W-1:0];
    acc_sat     = !((&acc_q[ACC_W-1:SUM_W-1]) || ~(|acc_q[ACC_W-1:SUM_W-1]));
  end

  always_comb begin
    wr_en         = (state_q == ST_FINISH) && !is_query_q && (found_q || has_room);
    wr_addr       = found_q ? hit_idx_q : count_q[AW-1:0];
    wr_entry.date = start_q;
    wr_entry.sum  = found_q ? upd_clamped : SUM_W'(amt_q);
  end

  darst_mem #(
    .DEPTH(MAX_ENTRIES)
  ) u_mem (
    .clk_i,
    .rd_en_i   (issue),
    .rd_addr_i (addr_q[AW-1:0]),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_entry_i(wr_entry),
    .rd_entry_o(rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      is_query_q   <= 1'b0;
      start_q      <= '0;
      end_q        <= '0;
      amt_q        <= '0;
      addr_q       <= '0;
      count_q      <= '0;
      pend_q       <= 1'b0;
      rd_idx_q     <= '0;
      found_q      <= 1'b0;
      hit_idx_q    <= '0;
      hit_sum_q    <= '0;
      acc_q        <= '0;
      status_q     <= STATUS_OK;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_total_q  <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready && (state_q != ST_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      pend_q <= issue;
      if (issue) begin
        addr_q   <= addr_q + CW'(1);
        rd_idx_q <= addr_q[AW-1:0];
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            is_query_q <= req_i.req_type == REQ_QUERY;
            start_q    <= req_i.start_date;
            end_q      <= req_i.end_date;
            amt_q      <= req_i.amount;
            addr_q     <= '0;
            found_q    <= 1'b0;
            acc_q      <= '0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (is_query_q && in_range) begin
            acc_q <= acc_q + ACC_W'(rd_entry.sum);
          end
          if (hit_add) begin
            found_q   <= 1'b1;
            hit_idx_q <= rd_idx_q;
            hit_sum_q <= rd_entry.sum;
            state_q   <= ST_FINISH;
          end else if (!issue && !pend_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          status_q <= STATUS_OK;
          total_q  <= '0;
          if (is_query_q) begin
            if (acc_sat) begin
              status_q <= STATUS_SAT;
              total_q  <= acc_q[ACC_W-1] ? SUM_MIN : SUM_MAX;
            end else begin
              total_q <= acc_q[SUM_W-1:0];
            end
          end else if (found_q) begin
            if (upd_sat) begin
              status_q <= STATUS_SAT;
            end
          end else if (has_room) begin
            count_q <= count_q + CW'(1);
          end else begin
            status_q <= STATUS_FULL;
          end
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_total_q  <= total_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready  = state_q == ST_IDLE;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.total  = out_total_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("fill count beyond table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
    else $error("fill count moved by more than one");

  a_pend_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_SCAN))
    else $error("read data returned outside scan");

  a_rsp_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_PUSH))
    else $error("result offered without a finished item");

  a_write_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (!is_query_q && !issue))
    else $error("entry write overlaps a scan read");

endmodule
